// ===== design/rcp_pkg.sv =====
// Package: shared types, widths and helper functions of the range coalescing planner.
package rcp_pkg;

   localparam int OFF_W = 48;
   localparam int LEN_W = 48;
   localparam int TOT_W = 54;
   localparam int CNT_W = 7;
   localparam logic [OFF_W-1:0] END_MAX = '1;
   localparam logic [OFF_W-1:0] GAP_RESET = 48'd1048576;

   // one stored range: offset and size
   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
   } span_type;

   // one result item
   typedef struct packed {
      logic [OFF_W-1:0] range_offset;
      logic [LEN_W-1:0] range_length;
      logic             range_valid;
      logic             strategy;
      logic [CNT_W-1:0] request_count;
      logic [TOT_W-1:0] transfer_total;
      logic             overflow;
      logic             last_range;
   } result_type;

   // range end, clipped at the top of the 48-bit space
   function automatic logic [OFF_W-1:0] sat_end(input logic [OFF_W-1:0] off,
                                               input logic [LEN_W-1:0] len);
      logic [OFF_W:0] sum;
      sum = {1'b0, off} + {1'b0, len};
      return sum[OFF_W] ? END_MAX : sum[OFF_W-1:0];
   endfunction

   // sort key compare: offset first, then size
   function automatic logic key_greater(input span_type a,
                                        input logic [OFF_W-1:0] off,
                                        input logic [LEN_W-1:0] len);
      return (a.off > off) || ((a.off == off) && (a.len > len));
   endfunction

endpackage

// ===== design/rcp_ifs.sv =====
// Interfaces: entry request channel, range result channel and register write channel.
interface rcp_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] entry_offset;
   logic [47:0] entry_size;
   logic        entry_found;
   logic        last_entry;
   modport source (output valid, entry_offset, entry_size, entry_found, last_entry,
                   input ready);
   modport sink (input valid, entry_offset, entry_size, entry_found, last_entry,
                 output ready);
endinterface

interface rcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] range_offset;
   logic [47:0] range_length;
   logic        range_valid;
   logic        strategy;
   logic [6:0]  request_count;
   logic [53:0] transfer_total;
   logic        overflow;
   logic        last_range;
   modport source (output valid, range_offset, range_length, range_valid, strategy,
                   request_count, transfer_total, overflow, last_range, input ready);
   modport sink (input valid, range_offset, range_length, range_valid, strategy,
                 request_count, transfer_total, overflow, last_range, output ready);
endinterface

interface rcp_csr_if;
   logic        valid;
   logic        ready;
   logic [47:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== design/range_coalescing_planner.sv =====
// Top level: loads entries into arrival and sorted memories and plans retrieval ranges.
// Entry load: a found entry is stored in the arrival memory and inserted into the sorted
// memory, shifting larger keys up one slot. Plan on the last entry: one sweep of the
// sorted memory sizes clusters, then a second cluster sweep or an arrival-order sweep
// emits one result item per range, stalling on the output register when the sink holds off.
// Reset clears counters, flags and control, presets gap_ff; both memories are undefined.
module range_coalescing_planner #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic      clock,
   input  logic      reset,
   rcp_req_if.sink   req_if,
   rcp_csr_if.sink   csr_if,
   rcp_rsp_if.source rsp_if
);
   import rcp_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_INS    = 6'b000010,
      S_CL_RD  = 6'b000100,
      S_CL_EX  = 6'b001000,
      S_IND_RD = 6'b010000,
      S_IND_EX = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    fc_ff, fc_in, ic_ff, ic_in, i_ff, i_in;
   logic [CW-1:0]    nz_ff, nz_in, emit_cnt_ff, emit_cnt_in;
   logic [AW-1:0]    p_ff, p_in;
   logic [TOT_W-1:0] size_sum_ff, size_sum_in, csum_ff, csum_in;
   logic             dropped_ff, dropped_in, last_ff, last_in;
   logic             pass2_ff, pass2_in, have_ff, have_in;
   logic [OFF_W-1:0] gap_ff, off_ff, off_in, cstart_ff, cstart_in, cend_ff, cend_in;
   logic [LEN_W-1:0] sz_ff, sz_in;

   // memories and their ports
   span_type         arrival_mem [MAX_ENTRIES];
   span_type         sorted_mem [MAX_ENTRIES];
   span_type         arr_rd_ff, srt_rd_ff, srt_wdata;
   logic             arr_we, arr_re, srt_we, srt_re;
   logic [AW-1:0]    srt_raddr, srt_waddr;

   // result path
   result_type       res;
   logic             emit, out_free;

   // cluster helpers on the sorted read data
   logic [OFF_W-1:0] o_cur, e_cur;
   logic [LEN_W-1:0] clen;
   logic [OFF_W:0]   thr;
   logic             newc, close_c, need_emit;
   logic [TOT_W-1:0] c_fin;
   logic [TOT_W+2:0] s5, c4;
   logic             clus;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   assign o_cur   = srt_rd_ff.off;
   assign e_cur   = sat_end(srt_rd_ff.off, srt_rd_ff.len);
   assign thr     = {1'b0, cend_ff} + {1'b0, gap_ff};
   assign newc    = !have_ff || ({1'b0, o_cur} > thr);
   assign clen    = cend_ff - cstart_ff;
   assign close_c = have_ff && newc;
   assign need_emit = pass2_ff && close_c && (clen != '0);
   assign c_fin   = csum_ff + (have_ff ? TOT_W'(clen) : '0);
   assign s5      = ((TOT_W+3)'(size_sum_ff) << 2) + (TOT_W+3)'(size_sum_ff);
   assign c4      = (TOT_W+3)'(c_fin) << 2;
   assign clus    = (size_sum_ff == '0) || (s5 > c4);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fc_in       = fc_ff;
      ic_in       = ic_ff;
      i_in        = i_ff;
      nz_in       = nz_ff;
      emit_cnt_in = emit_cnt_ff;
      p_in        = p_ff;
      size_sum_in = size_sum_ff;
      csum_in     = csum_ff;
      dropped_in  = dropped_ff;
      last_in     = last_ff;
      pass2_in    = pass2_ff;
      have_in     = have_ff;
      off_in      = off_ff;
      sz_in       = sz_ff;
      cstart_in   = cstart_ff;
      cend_in     = cend_ff;
      arr_we      = 1'b0;
      arr_re      = 1'b0;
      srt_we      = 1'b0;
      srt_re      = 1'b0;
      srt_raddr   = p_ff - AW'(1);
      srt_waddr   = p_ff;
      srt_wdata   = srt_rd_ff;
      emit        = 1'b0;
      res         = '0;
      res.overflow = dropped_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               off_in  = req_if.entry_offset;
               sz_in   = req_if.entry_size;
               last_in = req_if.last_entry;
               if (ic_ff < MAX_C) begin
                  ic_in = ic_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if ((ic_ff < MAX_C) && req_if.entry_found) begin
                  arr_we      = 1'b1;
                  size_sum_in = size_sum_ff + TOT_W'(req_if.entry_size);
                  fc_in       = fc_ff + CW'(1);
                  p_in        = fc_ff[AW-1:0];
                  srt_re      = 1'b1;
                  srt_raddr   = fc_ff[AW-1:0] - AW'(1);
                  state_in    = S_INS;
               end else if (req_if.last_entry) begin
                  state_in = S_CL_RD;
               end
               // plan setup, harmless when no plan follows
               i_in        = '0;
               pass2_in    = 1'b0;
               have_in     = 1'b0;
               csum_in     = '0;
               nz_in       = '0;
               emit_cnt_in = '0;
            end
         end
         S_INS: begin
            // shift larger keys up one slot, then drop the new entry in
            if ((p_ff != '0) && key_greater(srt_rd_ff, off_ff, sz_ff)) begin
               srt_we    = 1'b1;
               p_in      = p_ff - AW'(1);
               srt_re    = 1'b1;
               srt_raddr = p_ff - AW'(1) - AW'(1);
            end else begin
               srt_we    = 1'b1;
               srt_wdata = '{off: off_ff, len: sz_ff};
               state_in  = last_ff ? S_CL_RD : S_IDLE;
            end
         end
         S_CL_RD: begin
            if (i_ff == fc_ff) begin
               if (!pass2_ff) begin
                  csum_in = c_fin;
                  nz_in   = nz_ff + ((have_ff && (clen != '0)) ? CW'(1) : CW'(0));
                  i_in    = '0;
                  have_in = 1'b0;
                  if (clus) begin
                     pass2_in = 1'b1;
                  end else begin
                     state_in = S_IND_RD;
                  end
               end else if (out_free) begin
                  res.strategy       = 1'b1;
                  res.request_count  = CNT_W'(nz_ff);
                  res.transfer_total = csum_ff;
                  res.last_range     = 1'b1;
                  if (have_ff && (clen != '0)) begin
                     emit             = 1'b1;
                     res.range_offset = cstart_ff;
                     res.range_length = clen;
                     res.range_valid  = 1'b1;
                  end else if (nz_ff == '0) begin
                     emit = 1'b1;
                  end
                  fc_in       = '0;
                  ic_in       = '0;
                  size_sum_in = '0;
                  dropped_in  = 1'b0;
                  state_in    = S_IDLE;
               end
            end else begin
               srt_re    = 1'b1;
               srt_raddr = i_ff[AW-1:0];
               state_in  = S_CL_EX;
            end
         end
         S_CL_EX: begin
            if (!need_emit || out_free) begin
               if (need_emit) begin
                  emit               = 1'b1;
                  res.range_offset   = cstart_ff;
                  res.range_length   = clen;
                  res.range_valid    = 1'b1;
                  res.strategy       = 1'b1;
                  res.request_count  = CNT_W'(nz_ff);
                  res.transfer_total = csum_ff;
                  res.last_range     = ((emit_cnt_ff + CW'(1)) == nz_ff);
                  emit_cnt_in        = emit_cnt_ff + CW'(1);
               end
               if (close_c && !pass2_ff) begin
                  csum_in = csum_ff + TOT_W'(clen);
                  nz_in   = nz_ff + ((clen != '0) ? CW'(1) : CW'(0));
               end
               if (newc) begin
                  cstart_in = o_cur;
                  cend_in   = e_cur;
                  have_in   = 1'b1;
               end else if (e_cur > cend_ff) begin
                  cend_in = e_cur;
               end
               i_in     = i_ff + CW'(1);
               state_in = S_CL_RD;
            end
         end
         S_IND_RD: begin
            if (i_ff == fc_ff) begin
               fc_in       = '0;
               ic_in       = '0;
               size_sum_in = '0;
               dropped_in  = 1'b0;
               state_in    = S_IDLE;
            end else begin
               arr_re   = 1'b1;
               state_in = S_IND_EX;
            end
         end
         S_IND_EX: begin
            if (out_free) begin
               emit               = 1'b1;
               res.range_offset   = arr_rd_ff.off;
               res.range_length   = arr_rd_ff.len;
               res.range_valid    = 1'b1;
               res.strategy       = 1'b0;
               res.request_count  = CNT_W'(ic_ff);
               res.transfer_total = size_sum_ff;
               res.last_range     = ((i_ff + CW'(1)) == fc_ff);
               i_in               = i_ff + CW'(1);
               state_in           = S_IND_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fc_ff       <= '0;
         ic_ff       <= '0;
         i_ff        <= '0;
         nz_ff       <= '0;
         emit_cnt_ff <= '0;
         p_ff        <= '0;
         size_sum_ff <= '0;
         csum_ff     <= '0;
         dropped_ff  <= 1'b0;
         last_ff     <= 1'b0;
         pass2_ff    <= 1'b0;
         have_ff     <= 1'b0;
         gap_ff      <= GAP_RESET;
      end else begin
         state_ff    <= state_in;
         fc_ff       <= fc_in;
         ic_ff       <= ic_in;
         i_ff        <= i_in;
         nz_ff       <= nz_in;
         emit_cnt_ff <= emit_cnt_in;
         p_ff        <= p_in;
         size_sum_ff <= size_sum_in;
         csum_ff     <= csum_in;
         dropped_ff  <= dropped_in;
         last_ff     <= last_in;
         pass2_ff    <= pass2_in;
         have_ff     <= have_in;
         if (csr_if.valid) begin
            gap_ff <= csr_if.data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      off_ff    <= off_in;
      sz_ff     <= sz_in;
      cstart_ff <= cstart_in;
      cend_ff   <= cend_in;
   end

   // arrival-order memory
   always_ff @(posedge clock) begin
      if (arr_we) begin
         arrival_mem[fc_ff[AW-1:0]] <= '{off: req_if.entry_offset, len: req_if.entry_size};
      end
      if (arr_re) begin
         arr_rd_ff <= arrival_mem[i_ff[AW-1:0]];
      end
   end

   // sorted memory
   always_ff @(posedge clock) begin
      if (srt_we) begin
         sorted_mem[srt_waddr] <= srt_wdata;
      end
      if (srt_re) begin
         srt_rd_ff <= sorted_mem[srt_raddr];
      end
   end

   rcp_rsp_stage u_rsp_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (emit),
      .res    (res),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

`ifndef ASSERT_OFF
   a_found_le_items: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= ic_ff) else $error("found count exceeds item count");
   a_items_bounded: assert property (@(posedge clock) disable iff (reset)
      ic_ff <= MAX_C) else $error("item count beyond store size");
   a_emit_bounded: assert property (@(posedge clock) disable iff (reset)
      (emit && pass2_ff && (state_ff == S_CL_EX)) |-> (emit_cnt_ff < nz_ff))
      else $error("more clusters emitted than counted");
`endif

endmodule

// ===== design/rcp_rsp_stage.sv =====
// Result output register: holds one result item until the sink takes it.
module rcp_rsp_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rcp_pkg::result_type res,
   output logic               free,
   rcp_rsp_if.source          rsp_if
);
   import rcp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign free = !valid_ff || rsp_if.ready;

   // control: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.range_offset   = data_ff.range_offset;
   assign rsp_if.range_length   = data_ff.range_length;
   assign rsp_if.range_valid    = data_ff.range_valid;
   assign rsp_if.strategy       = data_ff.strategy;
   assign rsp_if.request_count  = data_ff.request_count;
   assign rsp_if.transfer_total = data_ff.transfer_total;
   assign rsp_if.overflow       = data_ff.overflow;
   assign rsp_if.last_range     = data_ff.last_range;

endmodule
